/* hw/rtl/console_receive_queue_assert.svh */
// Assertion macros shared by the console receive queue RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef CONSOLE_RECEIVE_QUEUE_ASSERT_SVH
`define CONSOLE_RECEIVE_QUEUE_ASSERT_SVH

// A condition that must hold at every edge outside reset.
`define CRQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequent that must hold in the same cycle as its antecedent.
`define CRQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequent that must hold in the cycle after its antecedent.
`define CRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/crq_pkg.sv */
`default_nettype none
package crq_pkg;

  localparam int CRQ_DEPTH = 1024;

  localparam logic [7:0] CRQ_BREAK_CODE = 8'd3;

  typedef enum logic [1:0] {
    OP_PUSH_RX  = 2'd0,
    OP_PUSH_RAW = 2'd1,
    OP_READ     = 2'd2,
    OP_TAKE_INT = 2'd3
  } crq_opcode_t;

  typedef enum logic [2:0] {
    ST_STORED  = 3'd0,
    ST_DROPPED = 3'd1,
    ST_BREAK   = 3'd2,
    ST_READ    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_FLUSHED = 3'd5,
    ST_INTR    = 3'd6
  } crq_status_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } crq_mem_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/crq_ring_mem.sv */
`default_nettype none
module crq_ring_mem
  import crq_pkg::*;
#(
  parameter int DEPTH = CRQ_DEPTH,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire crq_mem_ctl_t      ctl,
  input  wire logic [AddrW-1:0]  waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [AddrW-1:0]  raddr,
  output logic      [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // The read register only moves on a read, so a waiting result keeps its byte.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/console_receive_queue.sv */
// Console receive queue: byte ring with DEPTH-1 usable entries in one synchronous RAM.
// A result is presented in the cycle after its request beat is taken.
// Throughput: one request per cycle; the single result register stalls requests
// only while its result is held back.
// Reset (synchronous, active high) clears both pointers and both flags and the
// result valid; the ring RAM itself is not cleared.
`default_nettype none
`include "console_receive_queue_assert.svh"
module console_receive_queue
  import crq_pkg::*;
#(
  parameter int DEPTH = CRQ_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] rx_byte,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic      [2:0] status,
  output logic      [7:0] read_byte,
  output logic            interrupt_was_pending
);

  localparam int PtrW = $clog2(DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  logic [PtrW-1:0] wr_ptr, wr_ptr_next;
  logic [PtrW-1:0] rd_ptr, rd_ptr_next;
  logic            overflow, overflow_next;
  logic            break_pend, break_pend_next;
  logic [2:0]      status_next;
  logic            was_next;
  logic [PtrW-1:0] wr_succ, rd_succ;
  logic            full, empty, accept;
  logic [7:0]      wdata;
  logic [7:0]      rdata;
  crq_mem_ctl_t    mem_ctl;

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;

  assign wr_succ = (wr_ptr == LastIdx) ? '0 : wr_ptr + 1'b1;
  assign rd_succ = (rd_ptr == LastIdx) ? '0 : rd_ptr + 1'b1;
  assign full    = (wr_succ == rd_ptr);
  assign empty   = (wr_ptr == rd_ptr);

  always_comb begin
    wr_ptr_next     = wr_ptr;
    rd_ptr_next     = rd_ptr;
    overflow_next   = overflow;
    break_pend_next = break_pend;
    status_next     = ST_STORED;
    was_next        = 1'b0;
    wdata           = rx_byte;
    mem_ctl         = '0;
    case (crq_opcode_t'(opcode))
      OP_PUSH_RX, OP_PUSH_RAW: begin
        if (opcode == OP_PUSH_RAW) begin
          wdata = CRQ_BREAK_CODE;
        end
        if (opcode == OP_PUSH_RX && rx_byte == CRQ_BREAK_CODE) begin
          break_pend_next = 1'b1;
          status_next     = ST_BREAK;
        end else if (full) begin
          overflow_next = 1'b1;
          status_next   = ST_DROPPED;
        end else begin
          mem_ctl.wr_en = accept;
          wr_ptr_next   = wr_succ;
          status_next   = ST_STORED;
        end
      end
      OP_READ: begin
        if (overflow) begin
          overflow_next = 1'b0;
          rd_ptr_next   = wr_ptr;
          status_next   = ST_FLUSHED;
        end else if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          mem_ctl.rd_en = accept;
          rd_ptr_next   = rd_succ;
          status_next   = ST_READ;
        end
      end
      OP_TAKE_INT: begin
        was_next        = break_pend;
        break_pend_next = 1'b0;
        status_next     = ST_INTR;
      end
      default: begin
        status_next = ST_STORED;
      end
    endcase
  end

  // A write and a read never meet on one entry in the same cycle: a read
  // needs a non-empty ring, so the read entry is never the one at wr_ptr.
  crq_ring_mem #(
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .ctl  (mem_ctl),
    .waddr(wr_ptr),
    .wdata(wdata),
    .raddr(rd_ptr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      overflow   <= 1'b0;
      break_pend <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (accept) begin
        wr_ptr     <= wr_ptr_next;
        rd_ptr     <= rd_ptr_next;
        overflow   <= overflow_next;
        break_pend <= break_pend_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status                <= status_next;
      interrupt_was_pending <= was_next;
    end
  end

  assign read_byte = (status == ST_READ) ? rdata : 8'd0;

  `CRQ_ASSERT_ALWAYS(a_ptr_range, (wr_ptr <= LastIdx) && (rd_ptr <= LastIdx), "pointer out of range")
  `CRQ_ASSERT_IMP(a_no_write_full, mem_ctl.wr_en, wr_succ != rd_ptr, "ring write while full")
  `CRQ_ASSERT_IMP(a_no_read_empty, mem_ctl.rd_en, rd_ptr != wr_ptr, "ring read while empty")
  `CRQ_ASSERT_NEXT(a_flush, accept && (opcode == OP_READ) && overflow, (rd_ptr == wr_ptr) && !overflow, "overflow read did not flush the ring")

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench;
  import crq_pkg::*;

  localparam int HOLD_CYCLES = 60;

  typedef struct packed {
    crq_opcode_t op;
    logic [7:0]  data;
  } request_t;

  typedef struct packed {
    crq_status_t status;
    logic [7:0]  data;
    logic        intr;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic [1:0] opcode = 2'd0;
  logic [7:0] rx_byte = 8'd0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic [2:0] status;
  logic [7:0] read_byte;
  logic       interrupt_was_pending;

  request_t request_q[$];
  reply_t   reply_q[$];

  // Shadow copy of the ring and its flags, advanced at every accepted request beat.
  logic [7:0]  ring_copy [CRQ_DEPTH];
  int unsigned wr_idx;
  int unsigned rd_idx;
  bit          overflow_seen;
  bit          break_seen;

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_trigger = 0;
  int unsigned hold_seen;
  int unsigned hold_left;
  int unsigned error_count = 0;

  request_t next_req;
  request_t seen_req;
  reply_t   want_reply;

  console_receive_queue #(.DEPTH(CRQ_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .opcode(opcode),
    .rx_byte(rx_byte),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .status(status),
    .read_byte(read_byte),
    .interrupt_was_pending(interrupt_was_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic crq_status_t push_to_ring(input logic [7:0] b);
    int unsigned nxt;
    nxt = (wr_idx + 1) % CRQ_DEPTH;
    if (nxt == rd_idx) begin
      overflow_seen = 1'b1;
      return ST_DROPPED;
    end
    ring_copy[wr_idx] = b;
    wr_idx = nxt;
    return ST_STORED;
  endfunction

  function automatic reply_t predict_reply(input request_t req);
    reply_t r;
    r = '{status: ST_STORED, data: 8'd0, intr: 1'b0};
    case (req.op)
      OP_PUSH_RX: begin
        if (req.data == CRQ_BREAK_CODE) begin
          break_seen = 1'b1;
          r.status = ST_BREAK;
        end else begin
          r.status = push_to_ring(req.data);
        end
      end
      OP_PUSH_RAW: begin
        r.status = push_to_ring(CRQ_BREAK_CODE);
      end
      OP_READ: begin
        if (overflow_seen) begin
          // An overflow throws away everything still held in the ring.
          overflow_seen = 1'b0;
          rd_idx = wr_idx;
          r.status = ST_FLUSHED;
        end else if (rd_idx == wr_idx) begin
          r.status = ST_EMPTY;
        end else begin
          r.data = ring_copy[rd_idx];
          rd_idx = (rd_idx + 1) % CRQ_DEPTH;
          r.status = ST_READ;
        end
      end
      default: begin
        r.intr = break_seen;
        break_seen = 1'b0;
        r.status = ST_INTR;
      end
    endcase
    return r;
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = request_q.pop_front();
        req_valid <= 1'b1;
        opcode <= next_req.op;
        rx_byte <= next_req.data;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall.
  always @(posedge clk) begin
    if (rst) begin
      wr_idx = 0;
      rd_idx = 0;
      overflow_seen = 1'b0;
      break_seen = 1'b0;
      hold_seen = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        seen_req.op = crq_opcode_t'(opcode);
        seen_req.data = rx_byte;
        reply_q.push_back(predict_reply(seen_req));
      end
      if (rsp_valid && !rsp_stall) begin
        if (reply_q.size() == 0) begin
          $error("result beat with no request outstanding");
          error_count++;
        end else begin
          want_reply = reply_q.pop_front();
          if (status !== want_reply.status) begin
            $error("status: expected %0d, got %0d", want_reply.status, status);
            error_count++;
          end
          if (read_byte !== want_reply.data) begin
            $error("read_byte: expected %0d, got %0d", want_reply.data, read_byte);
            error_count++;
          end
          if (interrupt_was_pending !== want_reply.intr) begin
            $error("interrupt_was_pending: expected %0d, got %0d", want_reply.intr,
                   interrupt_was_pending);
            error_count++;
          end
        end
      end
      if (hold_seen != hold_trigger) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic add_req(input crq_opcode_t op, input logic [7:0] b);
    request_t r;
    r.op = op;
    r.data = b;
    request_q.push_back(r);
  endtask

  function automatic logic [7:0] random_byte();
    return ($urandom_range(9) == 0) ? CRQ_BREAK_CODE : 8'($urandom_range(255));
  endfunction

  // Mostly bursts of pushes drained by reads, with single random requests between.
  task automatic add_random(input int n);
    int count;
    int w;
    int k;
    crq_opcode_t op;
    count = 0;
    while (count < n) begin
      if ($urandom_range(99) < 60) begin
        k = $urandom_range(30, 2);
        repeat (k) add_req($urandom_range(7) == 0 ? OP_PUSH_RAW : OP_PUSH_RX, random_byte());
        repeat (k + $urandom_range(2)) add_req(OP_READ, 8'($urandom_range(255)));
        count += 2 * k;
      end else begin
        w = $urandom_range(99);
        op = (w < 35) ? OP_PUSH_RX : (w < 45) ? OP_PUSH_RAW : (w < 85) ? OP_READ : OP_TAKE_INT;
        add_req(op, random_byte());
        count++;
      end
    end
  endtask

  // A received break byte would not be stored, so the raw push stands in for it.
  task automatic fill_ring(input int n_push, input int n_read);
    logic [7:0] b;
    repeat (n_push) begin
      b = 8'($urandom_range(255));
      if (b == CRQ_BREAK_CODE) add_req(OP_PUSH_RAW, 8'($urandom_range(255)));
      else add_req(OP_PUSH_RX, b);
    end
    repeat (n_read) add_req(OP_READ, 8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || req_valid || reply_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    add_req(OP_READ, 8'h00);
    add_req(OP_TAKE_INT, 8'hFF);
    add_req(OP_PUSH_RX, 8'h00);
    add_req(OP_PUSH_RX, 8'hFF);
    add_req(OP_PUSH_RX, 8'h55);
    add_req(OP_PUSH_RX, 8'hAA);
    add_req(OP_PUSH_RX, 8'h02);
    add_req(OP_PUSH_RX, 8'h04);
    add_req(OP_PUSH_RX, CRQ_BREAK_CODE);
    add_req(OP_PUSH_RAW, 8'hFF);
    add_req(OP_TAKE_INT, 8'h00);
    add_req(OP_TAKE_INT, 8'hA5);
    repeat (7) add_req(OP_READ, 8'($urandom_range(255)));
    add_req(OP_READ, 8'hFF);

    // Long receiver hold-off while requests keep coming, so the input stalls.
    add_random(120);
    hold_trigger++;
    // A longer run of pushes, followed by one more read than there were pushes.
    fill_ring(40, 41);
    wait_drained();

    send_idle_pct = 73;
    add_random(130);
    wait_drained();

    send_idle_pct = 0;
    stall_pct = 73;
    add_random(130);
    hold_trigger++;
    wait_drained();

    send_idle_pct = 9;
    stall_pct = 9;
    add_random(100);
    fill_ring(20, 2);
    wait_drained();

    repeat (10) @(negedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/crq_pkg.sv
hw/rtl/crq_ring_mem.sv
hw/rtl/console_receive_queue.sv
tb/testbench.sv
